[src/utf8_code_point_encoder_core_macros.svh]
// Assertion macros for the UTF-8 encoder checker.
// Each macro samples on posedge clk and is disabled while rst_n is low.
`ifndef UTF8_CODE_POINT_ENCODER_CORE_MACROS_SVH
`define UTF8_CODE_POINT_ENCODER_CORE_MACROS_SVH

// same-cycle implication
`define U8E_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("u8e check failed");

// next-cycle implication
`define U8E_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("u8e check failed");

`endif

[src/u8e_pkg.sv]
// Shared types and constants for the UTF-8 code point encoder.
// Used by the classify, format and serializer stages and the top level.
package u8e_pkg;

  localparam int CpW      = 32;
  localparam int ValW     = 31;
  localparam int ByteW    = 8;
  localparam int MaxBytes = 6;
  localparam int LenW     = 3;
  localparam int RunW     = MaxBytes * ByteW;

  // classified code point: error flag, run length, value
  typedef struct packed {
    logic            err;
    logic [LenW-1:0] len;
    logic [ValW-1:0] value;
  } cls_t;

  // formatted run: byte 0 (lead) in the low bits
  typedef struct packed {
    logic            err;
    logic [LenW-1:0] cnt;
    logic [RunW-1:0] bytes;
  } fmt_t;

endpackage

[src/utf8_code_point_encoder_core.sv]
// Top level of the UTF-8 code point encoder (31-bit form, one to six bytes).
// Depends on u8e_pkg, u8e_classify, u8e_format and u8e_serial.
//
// Input channel: in_code_point with in_valid / in_stall; one code point per beat.
// Output channel: out_byte, out_last, out_error with out_valid / out_stall;
// one encoded byte per beat, lead byte first, out_last on the final byte of a run.
// A code point of 2^31 or more yields one beat with out_error = 1, out_byte = 0
// and out_last = 1.
//
// Three register stages: classify (range check, run length), format (lead and
// trailer bytes built in parallel) and serializer (shift register, one byte out
// per cycle unless out_stall is high). An item's first byte is offered once it
// has passed all three registers. The serializer sets throughput: it keeps a run
// until its final byte leaves and loads the next run in that cycle, so one-byte
// code points flow at one per cycle unless stalled; an n-byte one holds it for n bytes.
//
// Reset (rst_n low, synchronous) empties all stages; no output beat follows.
// When out_stall is high the current byte holds and, once every stage is full,
// in_stall rises; nothing is dropped or repeated.
module utf8_code_point_encoder_core
  import u8e_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [CpW-1:0]   in_code_point,
  output logic             in_stall,
  output logic             out_valid,
  output logic [ByteW-1:0] out_byte,
  output logic             out_last,
  output logic             out_error,
  input  logic             out_stall
);

  logic cls_valid;
  cls_t cls_data;
  logic cls_stall;
  logic fmt_valid;
  fmt_t fmt_data;
  logic fmt_stall;

  u8e_classify u_classify (
    .clk          (clk),
    .rst_n        (rst_n),
    .up_valid     (in_valid),
    .up_code_point(in_code_point),
    .up_stall     (in_stall),
    .dn_valid     (cls_valid),
    .dn_data      (cls_data),
    .dn_stall     (cls_stall)
  );

  u8e_format u_format (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_valid(cls_valid),
    .up_data (cls_data),
    .up_stall(cls_stall),
    .dn_valid(fmt_valid),
    .dn_data (fmt_data),
    .dn_stall(fmt_stall)
  );

  u8e_serial u_serial (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (fmt_valid),
    .up_data  (fmt_data),
    .up_stall (fmt_stall),
    .out_valid(out_valid),
    .out_byte (out_byte),
    .out_last (out_last),
    .out_error(out_error),
    .out_stall(out_stall)
  );

endmodule

[src/u8e_classify.sv]
// Stage 1: captures the code point, flags out-of-range values and sizes the run.
// Depends on u8e_pkg.
module u8e_classify
  import u8e_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  input  logic [CpW-1:0] up_code_point,
  output logic           up_stall,
  output logic           dn_valid,
  output cls_t           dn_data,
  input  logic           dn_stall
);

  logic            valid_r;
  cls_t            data_r;
  cls_t            data_nxt;
  logic [LenW-1:0] len_nxt;

  always_comb begin
    if (up_code_point < 32'h0000_0080) begin
      len_nxt = 3'd1;
    end else if (up_code_point < 32'h0000_0800) begin
      len_nxt = 3'd2;
    end else if (up_code_point < 32'h0001_0000) begin
      len_nxt = 3'd3;
    end else if (up_code_point < 32'h0020_0000) begin
      len_nxt = 3'd4;
    end else if (up_code_point < 32'h0400_0000) begin
      len_nxt = 3'd5;
    end else begin
      len_nxt = 3'd6;
    end
    data_nxt.err   = up_code_point[CpW-1];
    data_nxt.len   = up_code_point[CpW-1] ? 3'd1 : len_nxt;
    data_nxt.value = up_code_point[ValW-1:0];
  end

  assign up_stall = valid_r & dn_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!up_stall) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!up_stall) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

[src/u8e_format.sv]
// Stage 2: builds the lead byte and all trailer bytes of one run in parallel.
// Depends on u8e_pkg.
module u8e_format
  import u8e_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  input  cls_t up_data,
  output logic up_stall,
  output logic dn_valid,
  output fmt_t dn_data,
  input  logic dn_stall
);

  logic                  valid_r;
  fmt_t                  data_r;
  fmt_t                  data_nxt;
  logic [ByteW-1:0]      lead;
  logic [ByteW-1:0]      trail [MaxBytes-1];
  logic [ValW-1:0]       v;

  assign v = up_data.value;

  // trail[k] carries value bits [6k+5:6k]
  always_comb begin
    for (int k = 0; k < MaxBytes - 1; k++) begin
      trail[k] = {2'b10, v[6*k +: 6]};
    end
  end

  always_comb begin
    lead           = '0;
    data_nxt.bytes = '0;
    case (up_data.len)
      3'd1: begin
        lead           = {1'b0, v[6:0]};
        data_nxt.bytes = {40'd0, lead};
      end
      3'd2: begin
        lead           = {3'b110, v[10:6]};
        data_nxt.bytes = {32'd0, trail[0], lead};
      end
      3'd3: begin
        lead           = {4'b1110, v[15:12]};
        data_nxt.bytes = {24'd0, trail[0], trail[1], lead};
      end
      3'd4: begin
        lead           = {5'b11110, v[20:18]};
        data_nxt.bytes = {16'd0, trail[0], trail[1], trail[2], lead};
      end
      3'd5: begin
        lead           = {6'b111110, v[25:24]};
        data_nxt.bytes = {8'd0, trail[0], trail[1], trail[2], trail[3], lead};
      end
      3'd6: begin
        lead           = {7'b1111110, v[30]};
        data_nxt.bytes = {trail[0], trail[1], trail[2], trail[3], trail[4], lead};
      end
      default: begin
        lead           = '0;
        data_nxt.bytes = '0;
      end
    endcase
    if (up_data.err) begin
      data_nxt.bytes = '0;
    end
    data_nxt.err = up_data.err;
    data_nxt.cnt = up_data.len;
  end

  assign up_stall = valid_r & dn_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!up_stall) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!up_stall) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

[src/u8e_serial.sv]
// Stage 3: holds one formatted run and shifts it out one byte per beat.
// Depends on u8e_pkg.
module u8e_serial
  import u8e_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  input  fmt_t             up_data,
  output logic             up_stall,
  output logic             out_valid,
  output logic [ByteW-1:0] out_byte,
  output logic             out_last,
  output logic             out_error,
  input  logic             out_stall
);

  logic            valid_r;
  logic            valid_nxt;
  logic [RunW-1:0] sh_r;
  logic [RunW-1:0] sh_nxt;
  logic [LenW-1:0] cnt_r;
  logic [LenW-1:0] cnt_nxt;
  logic            err_r;
  logic            err_nxt;
  logic            fire;
  logic            last;

  assign last     = (cnt_r == 3'd1);
  assign fire     = valid_r & ~out_stall;
  // take a new run when empty or when the final byte leaves this cycle
  assign up_stall = valid_r & ~(fire & last);

  always_comb begin
    valid_nxt = valid_r;
    sh_nxt    = sh_r;
    cnt_nxt   = cnt_r;
    err_nxt   = err_r;
    if (!up_stall) begin
      valid_nxt = up_valid;
      sh_nxt    = up_data.bytes;
      cnt_nxt   = up_data.cnt;
      err_nxt   = up_data.err;
    end else if (fire) begin
      sh_nxt  = {{ByteW{1'b0}}, sh_r[RunW-1:ByteW]};
      cnt_nxt = cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    cnt_r <= cnt_nxt;
    err_r <= err_nxt;
  end

  assign out_valid = valid_r;
  assign out_byte  = sh_r[ByteW-1:0];
  assign out_last  = last;
  assign out_error = err_r;

endmodule

[src/u8e_checker.sv]
// Port-level checks for the UTF-8 encoder, bound to the top level.
// Depends on u8e_pkg and utf8_code_point_encoder_core_macros.svh.
`include "utf8_code_point_encoder_core_macros.svh"

module u8e_checker
  import u8e_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic [CpW-1:0]   in_code_point,
  input logic             in_stall,
  input logic             out_valid,
  input logic [ByteW-1:0] out_byte,
  input logic             out_last,
  input logic             out_error,
  input logic             out_stall
);

  // an error beat is a lone, empty, terminating beat
  `U8E_ASSERT_NOW(a_err_shape, out_valid && out_error, out_byte == 8'h00 && out_last)

  // a byte that is not the end of its run must be a lead or trailer byte
  `U8E_ASSERT_NOW(a_mid_high, out_valid && !out_last, out_byte[7] && !out_error)

  // after a non-final byte leaves, a trailer byte follows at once
  `U8E_ASSERT_NEXT(a_trail_next, out_valid && !out_stall && !out_last,
                   out_valid && out_byte[7:6] == 2'b10 && !out_error)

  // a stalled beat holds
  `U8E_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                   out_valid && $stable(out_byte) && $stable(out_last) && $stable(out_error))

  // a stalled input beat holds
  `U8E_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_code_point))

endmodule

bind utf8_code_point_encoder_core u8e_checker u_u8e_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_code_point(in_code_point),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_byte     (out_byte),
  .out_last     (out_last),
  .out_error    (out_error),
  .out_stall    (out_stall)
);
